>>> rtl/core/ftpt_pkg.sv
// Package for the flow table packet tracker core.
// Holds result status codes, register indexes and FNV constants; no dependencies.
package ftpt_pkg;

  typedef enum logic [1:0] {
    STATUS_DROP    = 2'd0,
    STATUS_NO_SYN  = 2'd1,
    STATUS_RECORD  = 2'd2,
    STATUS_OVERCAP = 2'd3
  } status_e;

  localparam logic [1:0] REG_EVICT_MODE = 2'd0;
  localparam logic [1:0] REG_RNG_SEED   = 2'd1;
  localparam logic [1:0] REG_UDP_IDLE   = 2'd2;

  localparam logic [31:0] FNV_OFFSET = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME  = 32'h01000193;
  localparam logic [31:0] SEED_RESET = 32'h12345678;
  localparam int unsigned HEX_DIGITS = 26;

  // Lower-case hex character of one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
  endfunction

endpackage

>>> rtl/core/flow_table_packet_tracker_core.sv
// Top level of the flow table packet tracker: sequencer, flow table memory, coin.
// Depends on ftpt_pkg and ftpt_hash.
//
//  channel | dir | handshake                    | payload
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tdata packet fields, tuser is_udp
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata result fields
//  cfg     | in  | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// From accept to a valid result a packet passes these steps: the hash starts on the
// registered canonical key, 26 hash digits run in the shared multiplier, the bucket is
// latched, the memory is read, compare/coin with write-back loads the result register,
// and the result is then flagged valid. After reset a clearing pass zeroes all
// TABLE_ENTRIES entries before the first word is accepted. The next word is accepted
// only once the result has been taken; a stalled result holds.
module flow_table_packet_tracker_core #(
  parameter int unsigned TABLE_ENTRIES    = 4096,
  parameter int unsigned PACKETS_PER_FLOW = 40
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_ip[31:0] dst_ip[63:32] src_port[79:64] dst_port[95:80] syn[96] fin[97]
  // ip_length[113:98] time_sec[145:114], zero fill to 152
  input  logic [151:0] s_axis_tdata,
  // is_udp[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // bucket[11:0] status[13:12] new_flow[14] evicted[15] packet_slot[21:16]
  // signed_length[38:22] flow_complete[39] expiry_sec[71:40]
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import ftpt_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  // entry: kaddr 64, kport 33, client 48, count 6, fin 2, valid 1
  localparam int unsigned EW = 154;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_DECIDE, S_OUT
  } state_e;

  state_e        state_q;
  logic [AW:0]   clr_q;
  logic          evict_mode_q;
  logic [31:0]   coin_q;
  logic [7:0]    idle_q;

  logic [31:0]   sip_q, tsec_q;
  logic [15:0]   spt_q, len_q;
  logic          udp_q, syn_q, fin_q;
  logic [63:0]   kaddr_q;
  logic [32:0]   kport_q;
  logic [AW-1:0] p_q;

  logic [EW-1:0] mem [TABLE_ENTRIES];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic          hstart, hdone;
  logic [31:0]   hash;
  logic [103:0]  hkey;
  logic [71:0]   out_q;
  logic          ovalid_q;

  // canonical key from the input word
  logic [31:0] a1, a2;
  logic [15:0] p1, p2;
  always_comb begin
    logic [31:0] si, di;
    logic [15:0] sp, dp;
    si = s_axis_tdata[31:0];
    di = s_axis_tdata[63:32];
    sp = s_axis_tdata[79:64];
    dp = s_axis_tdata[95:80];
    if (si < di) begin
      a1 = si; a2 = di; p1 = sp; p2 = dp;
    end else if (si > di) begin
      a1 = di; a2 = si; p1 = dp; p2 = sp;
    end else begin
      a1 = si; a2 = di;
      p1 = (sp < dp) ? sp : dp;
      p2 = (sp < dp) ? dp : sp;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign hstart = s_axis_tvalid && s_axis_tready;
  assign hkey = {kaddr_q[39:32], kaddr_q[47:40], kaddr_q[55:48], kaddr_q[63:56],
                 kport_q[32:17],
                 kaddr_q[7:0], kaddr_q[15:8], kaddr_q[23:16], kaddr_q[31:24],
                 kport_q[16:1],
                 (kport_q[0] ? 8'h11 : 8'h06)};

  // the key registers settle on the start edge, so the hash start goes through the hgo_q register
  logic hgo_q;
  ftpt_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hgo_q),
    .key_i  (hkey),
    .done_o (hdone),
    .hash_o (hash)
  );

  // decision on the read entry
  logic [63:0] e_kaddr;
  logic [32:0] e_kport;
  logic [47:0] e_cli, cli;
  logic [5:0]  e_cnt;
  logic [1:0]  e_fin;
  logic        e_val;
  logic [31:0] c1, c2, c3;
  logic [71:0] res;
  logic        coin_adv;
  always_comb begin
    logic [1:0]  status;
    logic        newf, evic, done, proceed, found, by_client;
    logic [5:0]  slot, cnt;
    logic [1:0]  fs;
    logic [16:0] flen;
    logic [31:0] ex;
    logic [47:0] ce;
    {e_kaddr, e_kport, e_cli, e_cnt, e_fin, e_val} = rd_q;
    cli = {sip_q, spt_q};
    c1 = coin_q ^ (coin_q << 13);
    c2 = c1 ^ (c1 >> 17);
    c3 = c2 ^ (c2 << 5);
    status = STATUS_DROP; newf = 1'b0; evic = 1'b0; done = 1'b0;
    slot = '0; flen = '0; ex = '0; proceed = 1'b1; found = 1'b0;
    coin_adv = 1'b0; cnt = e_cnt; fs = e_fin; ce = e_cli;
    we = 1'b0; wdata = rd_q; by_client = 1'b0;
    if (e_val) begin
      if (e_kaddr == kaddr_q && e_kport == kport_q) begin
        found = 1'b1;
      end else if (!evict_mode_q) begin
        proceed = 1'b0;
      end else begin
        coin_adv = 1'b1;
        if (!c3[0]) begin
          proceed = 1'b0;
        end else begin
          evic = 1'b1;
          we = 1'b1;
          wdata = '0;
        end
      end
    end
    if (proceed && !found) begin
      if (!udp_q && !syn_q) begin
        status = STATUS_NO_SYN;
        proceed = 1'b0;
      end else begin
        newf = 1'b1; ce = cli; cnt = '0; fs = '0;
      end
    end
    if (proceed) begin
      by_client = (ce == cli);
      flen = by_client ? {1'b0, len_q} : (17'd0 - {1'b0, len_q});
      if (cnt < 6'(PACKETS_PER_FLOW)) begin
        slot = cnt;
        cnt = cnt + 6'd1;
        status = STATUS_RECORD;
      end else begin
        status = STATUS_OVERCAP;
      end
      we = 1'b1;
      wdata = {kaddr_q, kport_q, ce, cnt, fs, 1'b1};
      if (!udp_q) begin
        if (fin_q) begin
          fs = fs | (by_client ? 2'b01 : 2'b10);
          wdata = {kaddr_q, kport_q, ce, cnt, fs, 1'b1};
          if (fs == 2'b11 && cnt == 6'(PACKETS_PER_FLOW)) begin
            wdata = '0;
            done = 1'b1;
          end
        end
      end else begin
        ex = tsec_q + {24'd0, idle_q};
      end
    end
    res = {ex, done, flen, slot, evic, newf, status, 12'(p_q)};
  end

  assign waddr = (state_q == S_CLEAR) ? clr_q[AW-1:0] : p_q;

  always_ff @(posedge clk_i) begin
    if ((state_q == S_CLEAR) || (state_q == S_DECIDE && we)) begin
      mem[waddr] <= (state_q == S_CLEAR) ? '0 : wdata;
    end
    rd_q <= mem[p_q];
  end

  always_ff @(posedge clk_i) begin
    if (hstart) begin
      sip_q <= s_axis_tdata[31:0];
      spt_q <= s_axis_tdata[79:64];
      syn_q <= s_axis_tdata[96];
      fin_q <= s_axis_tdata[97];
      len_q <= s_axis_tdata[113:98];
      tsec_q <= s_axis_tdata[145:114];
      udp_q <= s_axis_tuser;
      kaddr_q <= {a1, a2};
      kport_q <= {p1, p2, s_axis_tuser};
    end
    if (hdone) p_q <= hash[AW-1:0];
    if (state_q == S_DECIDE) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      evict_mode_q <= 1'b0;
      coin_q       <= SEED_RESET;
      idle_q       <= 8'd30;
      ovalid_q     <= 1'b0;
      hgo_q        <= 1'b0;
    end else begin
      hgo_q <= hstart;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_EVICT_MODE: evict_mode_q <= cfg_data_i[0];
          REG_RNG_SEED:   coin_q       <= cfg_data_i;
          REG_UDP_IDLE:   idle_q       <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(TABLE_ENTRIES - 1)) state_q <= S_IDLE;
        end
        S_IDLE:   if (hstart) state_q <= S_HASH;
        S_HASH:   if (hdone) state_q <= S_READ;
        S_READ:   state_q <= S_DECIDE;
        S_DECIDE: begin
          if (coin_adv) coin_q <= c3;
          state_q <= S_OUT;
        end
        S_OUT: begin
          ovalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;
endmodule

>>> rtl/core/ftpt_hash.sv
// Iterative FNV-1a 32 over the 26-digit hex key string, one digit a cycle.
// Uses ftpt_pkg for the FNV constants and the hex character function.
module ftpt_hash (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [103:0] key_i,
  output logic         done_o,
  output logic [31:0]  hash_o
);
  import ftpt_pkg::*;

  logic [103:0] sh_q, sh_d;
  logic [31:0]  h_q, h_d;
  logic [4:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;

  always_comb begin
    sh_d   = sh_q;
    h_d    = h_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = key_i;
      h_d    = FNV_OFFSET;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one digit: xor character, multiply by the prime
      h_d   = (h_q ^ {24'd0, hex_char(sh_q[103:100])}) * FNV_PRIME;
      sh_d  = {sh_q[99:0], 4'd0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(HEX_DIGITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    h_q  <= h_d;
  end

  assign done_o = done_q;
  assign hash_o = h_q;
endmodule

>>> rtl/core/ftpt_checker.sv
// Port-level checker for the flow table packet tracker core, with its bind.
// Depends only on the top level's ports.
module ftpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  // a held result keeps its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // no word taken while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");
  // an accepted word is followed by a busy period
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("ready after accept");
  // status zero or one carries no slot or length
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[13] |-> m_axis_tdata[38:16] == 23'd0)
    else $error("dropped packet carries slot or length");
endmodule

bind flow_table_packet_tracker_core ftpt_checker u_ftpt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
